// ----- rtl/core/tpc_pkg.sv -----
package tpc_pkg;

  localparam int CoordW = 16;
  localparam int DepthW = 16;
  localparam int PixW = 12;
  localparam int ScreenW = 13;
  localparam int WeightW = 16;
  localparam int DiffW = CoordW + 1;
  localparam int AreaW = 2 * DiffW;
  localparam int HalfW = AreaW / 2;
  localparam int SumW = DepthW + AreaW + 2;
  localparam int Lanes = 4;
  localparam int LaneDepth = 3;

  localparam int CoordFracBitsDef = 4;
  localparam int MaxScreenDef = 4096;
  localparam int QueueDepthDef = 4;
  localparam int DegenScale = 100;

  localparam logic [ScreenW-1:0] ScreenWidthRst = 13'd640;
  localparam logic [ScreenW-1:0] ScreenHeightRst = 13'd480;

  localparam int AddrW = 3;
  localparam int DataW = 32;

  typedef enum logic {
    REG_SCREEN_WIDTH = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } tpc_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by_coord;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic [DepthW-1:0] depth_a;
    logic [DepthW-1:0] depth_b;
    logic [DepthW-1:0] depth_c;
    logic [PixW-1:0] pixel_x;
    logic [PixW-1:0] pixel_y;
  } tpc_in_t;

  typedef struct packed {
    logic covered;
    logic degenerate;
    logic [WeightW-1:0] weight_a;
    logic [WeightW-1:0] weight_b;
    logic [WeightW-1:0] weight_c;
    logic [DepthW-1:0] pixel_depth;
  } tpc_out_t;

  typedef struct packed {
    logic covered;
    logic degenerate;
    logic [AreaW-1:0] area;
    logic [2:0][AreaW-1:0] num;
    logic [2:0] sat;
    logic [2:0][DepthW-1:0] depth;
  } tpc_job_t;

  typedef struct packed {
    logic covered;
    logic degenerate;
    logic [2:0] sat;
    logic [AreaW-1:0] area;
    logic [Lanes-1:0][AreaW-1:0] rem;
    logic [DepthW-1:0] dlo;
    logic [Lanes-1:0][WeightW-1:0] quo;
  } tpc_div_t;

endpackage

// ----- rtl/core/tpc_front.sv -----
module tpc_front import tpc_pkg::*; #(
  parameter int COORD_FRAC_BITS = CoordFracBitsDef,
  parameter int MAX_SCREEN = MaxScreenDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  tpc_in_t in_data_i,
  output logic in_stall_o,
  input  logic [ScreenW-1:0] screen_width_i,
  input  logic [ScreenW-1:0] screen_height_i,
  output logic job_valid_o,
  output tpc_job_t job_o,
  input  logic job_full_i
);

  localparam int PW = ((PixW + COORD_FRAC_BITS) > CoordW ? (PixW + COORD_FRAC_BITS) : CoordW) + 2;
  localparam int PrW = DiffW + PW;
  localparam int XW = PrW + 1;
  localparam int NW = XW + 2;
  localparam int ZW = AreaW + 1;
  localparam int LW = ($clog2(MAX_SCREEN + 1) > ScreenW) ? $clog2(MAX_SCREEN + 1) : ScreenW;
  localparam int DegenLim = ((1 << (2 * COORD_FRAC_BITS)) + DegenScale - 1) / DegenScale;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q;

  logic signed [DiffW-1:0] abx_d, aby_d, acx_d, acy_d;
  logic signed [DiffW-1:0] abx_q, aby_q, acx_q, acy_q;
  logic signed [PW-1:0] pfx, pfy, pax_d, pay_d, pax_q, pay_q;
  logic [2:0][DepthW-1:0] dep1_q, dep2_q, dep3_q;
  logic on1_q, on2_q, on3_q;
  logic [LW-1:0] wlim, hlim;

  logic signed [PrW-1:0] p1_q, p2_q, p3_q, p4_q;
  logic signed [AreaW-1:0] p5_q, p6_q;
  logic signed [XW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;

  logic signed [NW-1:0] na, nb, nc;
  logic signed [ZW-1:0] zabs;
  logic [AreaW-1:0] area;
  logic degen, cov;
  tpc_job_t job_d, job_q;

  assign en = !v4_q || !job_full_i;
  assign in_stall_o = !en;
  assign job_valid_o = v4_q;
  assign job_o = job_q;

  always_comb begin
    abx_d = DiffW'(in_data_i.bx) - DiffW'(in_data_i.ax);
    aby_d = DiffW'(in_data_i.by_coord) - DiffW'(in_data_i.ay);
    acx_d = DiffW'(in_data_i.cx) - DiffW'(in_data_i.ax);
    acy_d = DiffW'(in_data_i.cy) - DiffW'(in_data_i.ay);
    pfx = signed'(PW'(in_data_i.pixel_x) << COORD_FRAC_BITS);
    pfy = signed'(PW'(in_data_i.pixel_y) << COORD_FRAC_BITS);
    pax_d = PW'(in_data_i.ax) - pfx;
    pay_d = PW'(in_data_i.ay) - pfy;
    wlim = (LW'(screen_width_i) > LW'(MAX_SCREEN)) ? LW'(MAX_SCREEN) : LW'(screen_width_i);
    hlim = (LW'(screen_height_i) > LW'(MAX_SCREEN)) ? LW'(MAX_SCREEN) : LW'(screen_height_i);
  end

  always_comb begin
    na = NW'(z_q) - NW'(x_q) - NW'(y_q);
    nb = NW'(x_q);
    nc = NW'(y_q);
    zabs = z_q;
    if (z_q[ZW-1]) begin
      na = -na;
      nb = -nb;
      nc = -nc;
      zabs = -z_q;
    end
    area = zabs[AreaW-1:0];
    degen = area < AreaW'(DegenLim);
    cov = on3_q && !degen && !na[NW-1] && !nb[NW-1] && !nc[NW-1];
    job_d.covered = cov;
    job_d.degenerate = degen;
    job_d.area = area;
    job_d.num[0] = na[AreaW-1:0];
    job_d.num[1] = nb[AreaW-1:0];
    job_d.num[2] = nc[AreaW-1:0];
    job_d.sat[0] = na[AreaW-1:0] == area;
    job_d.sat[1] = nb[AreaW-1:0] == area;
    job_d.sat[2] = nc[AreaW-1:0] == area;
    job_d.depth = dep3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      abx_q <= abx_d;
      aby_q <= aby_d;
      acx_q <= acx_d;
      acy_q <= acy_d;
      pax_q <= pax_d;
      pay_q <= pay_d;
      dep1_q <= {in_data_i.depth_c, in_data_i.depth_b, in_data_i.depth_a};
      on1_q <= (LW'(in_data_i.pixel_x) < wlim) && (LW'(in_data_i.pixel_y) < hlim);
      p1_q <= acx_q * pay_q;
      p2_q <= pax_q * acy_q;
      p3_q <= pax_q * aby_q;
      p4_q <= abx_q * pay_q;
      p5_q <= abx_q * acy_q;
      p6_q <= acx_q * aby_q;
      dep2_q <= dep1_q;
      on2_q <= on1_q;
      x_q <= XW'(p1_q) - XW'(p2_q);
      y_q <= XW'(p3_q) - XW'(p4_q);
      z_q <= ZW'(p5_q) - ZW'(p6_q);
      dep3_q <= dep2_q;
      on3_q <= on2_q;
      job_q <= job_d;
    end
  end

endmodule

// ----- rtl/core/tpc_queue.sv -----
module tpc_queue import tpc_pkg::*; #(
  parameter int DEPTH = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  tpc_job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output tpc_job_t pop_data_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  tpc_job_t mem_q [DEPTH];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o = cnt_q == CW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign pop_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/core/tpc_back.sv -----
module tpc_back import tpc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_empty_i,
  input  tpc_job_t job_i,
  output logic job_pop_o,
  output logic out_valid_o,
  output tpc_out_t out_data_o,
  input  logic out_stall_i
);

  localparam int Steps = WeightW;
  localparam int PpW = DepthW + HalfW;

  logic en;
  logic b1_v_q, b2_v_q, out_v_q;
  tpc_job_t b1_job_q;
  logic [2:0][PpW-1:0] lo_q, hi_q;
  logic [SumW-1:0] sum;
  tpc_div_t init_d;
  tpc_div_t stage_q [Steps+1];
  logic [Steps:1] sv_q;
  tpc_div_t stage_d [1:Steps];
  tpc_out_t out_d, out_q;

  assign en = !out_v_q || !out_stall_i;
  assign job_pop_o = !job_empty_i && en;
  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;

  always_comb begin
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      sum = sum + SumW'(lo_q[k]) + (SumW'(hi_q[k]) << HalfW);
    end
    init_d.covered = b1_job_q.covered;
    init_d.degenerate = b1_job_q.degenerate;
    init_d.sat = b1_job_q.sat;
    init_d.area = b1_job_q.area;
    for (int k = 0; k < 3; k++) begin
      init_d.rem[k] = b1_job_q.sat[k] ? '0 : b1_job_q.num[k];
    end
    init_d.rem[LaneDepth] = sum[WeightW +: AreaW];
    init_d.dlo = sum[WeightW-1:0];
    init_d.quo = '0;
  end

  for (genvar s = 1; s <= Steps; s++) begin : g_div
    always_comb begin
      logic [AreaW:0] t;
      stage_d[s] = stage_q[s-1];
      for (int l = 0; l < Lanes; l++) begin
        t = {stage_q[s-1].rem[l], (l == LaneDepth) ? stage_q[s-1].dlo[WeightW-1] : 1'b0};
        if (t >= {1'b0, stage_q[s-1].area}) begin
          t = t - {1'b0, stage_q[s-1].area};
          stage_d[s].quo[l] = {stage_q[s-1].quo[l][WeightW-2:0], 1'b1};
        end else begin
          stage_d[s].quo[l] = {stage_q[s-1].quo[l][WeightW-2:0], 1'b0};
        end
        stage_d[s].rem[l] = t[AreaW-1:0];
      end
      stage_d[s].dlo = {stage_q[s-1].dlo[WeightW-2:0], 1'b0};
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        stage_q[s] <= stage_d[s];
      end
    end
  end

  always_comb begin
    out_d.covered = stage_q[Steps].covered;
    out_d.degenerate = stage_q[Steps].degenerate;
    out_d.weight_a = '0;
    out_d.weight_b = '0;
    out_d.weight_c = '0;
    out_d.pixel_depth = '0;
    if (stage_q[Steps].covered) begin
      out_d.weight_a = stage_q[Steps].sat[0] ? '1 : stage_q[Steps].quo[0];
      out_d.weight_b = stage_q[Steps].sat[1] ? '1 : stage_q[Steps].quo[1];
      out_d.weight_c = stage_q[Steps].sat[2] ? '1 : stage_q[Steps].quo[2];
      out_d.pixel_depth = stage_q[Steps].quo[LaneDepth];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
      sv_q <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      b1_v_q <= job_pop_o;
      b2_v_q <= b1_v_q;
      sv_q <= {sv_q[Steps-1:1], b2_v_q};
      out_v_q <= sv_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_job_q <= job_i;
      for (int k = 0; k < 3; k++) begin
        lo_q[k] <= job_i.depth[k] * job_i.num[k][HalfW-1:0];
        hi_q[k] <= job_i.depth[k] * job_i.num[k][AreaW-1:HalfW];
      end
      stage_q[0] <= init_d;
      out_q <= out_d;
    end
  end

endmodule

// ----- rtl/core/triangle_pixel_coverage.sv -----
// Channel | Valid      | Stall      | Payload
// input   | in_valid_i | in_stall_o | in_data_i (tpc_in_t)
// output  | out_valid_o| out_stall_i| out_data_o (tpc_out_t)
// config  | psel, penable, pwrite, pready | - | paddr, pwdata, prdata
// One query is taken per cycle while in_stall_o is low; each result passes through four front
// stages, the queue, two depth product stages, sixteen divider stages of one quotient bit
// each and an output register. Reset clears all valid flags and the queue and loads the
// screen size registers with 640 by 480. A stalled output freezes the back pipeline only;
// the front keeps taking queries until the queue fills.
module triangle_pixel_coverage import tpc_pkg::*; #(
  parameter int COORD_FRAC_BITS = CoordFracBitsDef,
  parameter int MAX_SCREEN = MaxScreenDef,
  parameter int QUEUE_DEPTH = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  tpc_in_t in_data_i,
  output logic in_stall_o,
  output logic out_valid_o,
  output tpc_out_t out_data_o,
  input  logic out_stall_i,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic pready
);

  logic [ScreenW-1:0] width_q, height_q;
  logic job_valid, job_full, job_empty, job_pop;
  tpc_job_t job_front, job_back;
  tpc_reg_e sel;

  assign pready = 1'b1;
  assign sel = tpc_reg_e'(paddr[2]);

  always_comb begin
    case (sel)
      REG_SCREEN_WIDTH: prdata = DataW'(width_q);
      REG_SCREEN_HEIGHT: prdata = DataW'(height_q);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= ScreenWidthRst;
      height_q <= ScreenHeightRst;
    end else if (psel && penable && pwrite) begin
      case (sel)
        REG_SCREEN_WIDTH: width_q <= pwdata[ScreenW-1:0];
        REG_SCREEN_HEIGHT: height_q <= pwdata[ScreenW-1:0];
        default: ;
      endcase
    end
  end

  tpc_front #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .MAX_SCREEN(MAX_SCREEN)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_data_i,
    .in_stall_o,
    .screen_width_i(width_q),
    .screen_height_i(height_q),
    .job_valid_o(job_valid),
    .job_o(job_front),
    .job_full_i(job_full)
  );

  tpc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i(job_valid),
    .push_data_i(job_front),
    .full_o(job_full),
    .pop_i(job_pop),
    .empty_o(job_empty),
    .pop_data_o(job_back)
  );

  tpc_back u_back (
    .clk_i,
    .rst_ni,
    .job_empty_i(job_empty),
    .job_i(job_back),
    .job_pop_o(job_pop),
    .out_valid_o,
    .out_data_o,
    .out_stall_i
  );

endmodule

// ----- rtl/core/tpc_checker.sv -----
module tpc_checker import tpc_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_stall_i,
  input tpc_out_t out_data_o
);

  logic [WeightW+1:0] wsum;

  assign wsum = (WeightW + 2)'(out_data_o.weight_a) + (WeightW + 2)'(out_data_o.weight_b)
              + (WeightW + 2)'(out_data_o.weight_c);

  // A stalled result stays on offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.covered && out_data_o.degenerate))
    else $error("degenerate triangle reported as covering");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.covered |->
      out_data_o.weight_a == '0 && out_data_o.weight_b == '0 &&
      out_data_o.weight_c == '0 && out_data_o.pixel_depth == '0)
    else $error("uncovered result carries weights or depth");

  // Floored weights of a covered pixel add up to within two of one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.covered |->
      wsum >= (WeightW + 2)'(65534) && wsum <= (WeightW + 2)'(65536))
    else $error("weights of a covered pixel do not add up to one");

endmodule

bind triangle_pixel_coverage tpc_checker u_tpc_checker (.*);

// ----- tb/sv/tpc_coverage_checker.sv -----
`timescale 1ns / 100ps

module tpc_coverage_checker import tpc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  tpc_in_t in_data_i,
  input  logic in_stall_i,
  input  logic out_valid_i,
  input  tpc_out_t out_data_i,
  input  logic out_stall_i,
  input  logic psel_i,
  input  logic penable_i,
  input  logic pwrite_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [DataW-1:0] pwdata_i,
  input  logic pready_i,
  output int errors_o,
  output int pending_o,
  output int covered_seen_o,
  output int degen_seen_o
);

  localparam int FracBits = 4;
  localparam int ScreenCap = 4096;

  logic [ScreenW-1:0] width_q;
  logic [ScreenW-1:0] height_q;
  tpc_out_t coverage_q[$];

  function automatic tpc_out_t predict_coverage(tpc_in_t q);
    longint ax, ay, bx, by, cx, cy, pfx, pfy;
    longint abx, aby, acx, acy, pax, pay;
    longint x, y, z, na, nb, nc, az, dep;
    longint wlim, hlim;
    logic on_screen;
    tpc_out_t r;
    ax = longint'(q.ax);
    ay = longint'(q.ay);
    bx = longint'(q.bx);
    by = longint'(q.by_coord);
    cx = longint'(q.cx);
    cy = longint'(q.cy);
    pfx = longint'(q.pixel_x) <<< FracBits;
    pfy = longint'(q.pixel_y) <<< FracBits;
    abx = bx - ax;
    aby = by - ay;
    acx = cx - ax;
    acy = cy - ay;
    pax = ax - pfx;
    pay = ay - pfy;
    x = acx * pay - pax * acy;
    y = pax * aby - abx * pay;
    z = abx * acy - acx * aby;
    na = z - x - y;
    nb = x;
    nc = y;
    az = z;
    if (z < 0) begin
      na = -na;
      nb = -nb;
      nc = -nc;
      az = -z;
    end
    wlim = (width_q > ScreenCap) ? ScreenCap : longint'(width_q);
    hlim = (height_q > ScreenCap) ? ScreenCap : longint'(height_q);
    on_screen = (longint'(q.pixel_x) < wlim) && (longint'(q.pixel_y) < hlim);
    r = '0;
    r.degenerate = (az * 100) < (longint'(1) <<< (2 * FracBits));
    r.covered = on_screen && !r.degenerate && na >= 0 && nb >= 0 && nc >= 0;
    if (r.covered) begin
      r.weight_a = ((na <<< 16) / az > 65535) ? 16'hFFFF : 16'((na <<< 16) / az);
      r.weight_b = ((nb <<< 16) / az > 65535) ? 16'hFFFF : 16'((nb <<< 16) / az);
      r.weight_c = ((nc <<< 16) / az > 65535) ? 16'hFFFF : 16'((nc <<< 16) / az);
      dep = (longint'(q.depth_a) * na + longint'(q.depth_b) * nb
             + longint'(q.depth_c) * nc) / az;
      r.pixel_depth = (dep > 65535) ? 16'hFFFF : 16'(dep);
    end
    return r;
  endfunction

  task automatic compare_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      errors_o++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tpc_out_t exp_r;
    if (!rst_ni) begin
      width_q <= ScreenWidthRst;
      height_q <= ScreenHeightRst;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i[1:0] == 2'b00) begin
        case (tpc_reg_e'(paddr_i[2]))
          REG_SCREEN_WIDTH: width_q <= pwdata_i[ScreenW-1:0];
          REG_SCREEN_HEIGHT: height_q <= pwdata_i[ScreenW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        coverage_q.insert(coverage_q.size(), predict_coverage(in_data_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (coverage_q.size() == 0) begin
          errors_o++;
          $display("%0t: result transfer with nothing expected, actual %h",
                   $time, out_data_i);
        end else begin
          exp_r = coverage_q.pop_front();
          if (exp_r.covered) covered_seen_o++;
          if (exp_r.degenerate) degen_seen_o++;
          compare_field("covered", exp_r.covered, out_data_i.covered);
          compare_field("degenerate", exp_r.degenerate, out_data_i.degenerate);
          compare_field("weight_a", exp_r.weight_a, out_data_i.weight_a);
          compare_field("weight_b", exp_r.weight_b, out_data_i.weight_b);
          compare_field("weight_c", exp_r.weight_c, out_data_i.weight_c);
          compare_field("pixel_depth", exp_r.pixel_depth, out_data_i.pixel_depth);
        end
      end
    end
    pending_o = coverage_q.size();
  end

  initial begin
    errors_o = 0;
    pending_o = 0;
    covered_seen_o = 0;
    degen_seen_o = 0;
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import tpc_pkg::*;

  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid;
  tpc_in_t in_data;
  logic in_stall;
  logic out_valid;
  tpc_out_t out_data;
  logic out_stall;
  logic psel, penable, pwrite, pready;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata, prdata;

  int errors, pending, covered_seen, degen_seen;
  int cycles = 0;
  int items_sent = 0;
  bit no_idle = 1'b0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int cur_w = 640;

  always #10 clk_i = ~clk_i;

  triangle_pixel_coverage DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_data_i(in_data), .in_stall_o(in_stall),
    .out_valid_o(out_valid), .out_data_o(out_data), .out_stall_i(out_stall),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tpc_coverage_checker checker_inst (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_data_i(in_data), .in_stall_i(in_stall),
    .out_valid_i(out_valid), .out_data_i(out_data), .out_stall_i(out_stall),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .errors_o(errors), .pending_o(pending),
    .covered_seen_o(covered_seen), .degen_seen_o(degen_seen)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The long hold-off is counted here, independently of the sender.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold_request || hold_left > 0) begin
      if (hold_request) begin
        hold_left = 300;
        hold_request = 1'b0;
      end
      hold_left--;
      out_stall <= 1'b1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 34);
    end
  end

  task automatic send_query(tpc_in_t q);
    while (!no_idle && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= q;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic write_reg(tpc_reg_e idx, int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(int'(idx) * 4);
    pwdata <= DataW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic tpc_in_t make_query(int ax, int ay, int bx, int by, int cx, int cy,
                                         int px, int py);
    tpc_in_t q;
    q.ax = 16'(ax);
    q.ay = 16'(ay);
    q.bx = 16'(bx);
    q.by_coord = 16'(by);
    q.cx = 16'(cx);
    q.cy = 16'(cy);
    q.depth_a = 16'($urandom);
    q.depth_b = 16'($urandom);
    q.depth_c = 16'($urandom);
    q.pixel_x = 12'(px);
    q.pixel_y = 12'(py);
    return q;
  endfunction

  function automatic tpc_in_t random_query();
    tpc_in_t q;
    int px, py, span;
    logic [191:0] raw;
    if ($urandom_range(99) < 25) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      q = raw[$bits(tpc_in_t)-1:0];
    end else begin
      px = $urandom_range((cur_w > 4095) ? 4095 : cur_w);
      py = $urandom_range(600);
      span = ($urandom_range(3) == 0) ? $urandom_range(30000) : $urandom_range(400);
      q = make_query(px * 16 + $urandom_range(span) - span / 4,
                     py * 16 + $urandom_range(span) - span / 4,
                     px * 16 + $urandom_range(span) - span / 4,
                     py * 16 - $urandom_range(span),
                     px * 16 - $urandom_range(span),
                     py * 16 + $urandom_range(span) - span / 4, px, py);
      if ($urandom_range(3) == 0) q.pixel_y = 12'($urandom_range(4095));
    end
    return q;
  endfunction

  task automatic directed_queries();
    tpc_in_t q;
    send_query(make_query(0, 0, 1600, 0, 0, 1600, 10, 10));
    send_query(make_query(0, 0, 0, 1600, 1600, 0, 10, 10));
    send_query(make_query(160, 160, 1600, 160, 160, 1600, 10, 10));
    send_query(make_query(160, 160, 1600, 160, 160, 1600, 50, 10));
    send_query(make_query(160, 160, 1600, 160, 160, 1600, 40, 10));
    send_query(make_query(5, 5, 5, 5, 5, 5, 0, 0));
    send_query(make_query(0, 0, 1, 0, 0, 1, 0, 0));
    send_query(make_query(0, 0, 1, 0, 0, 2, 0, 0));
    send_query(make_query(5, 5, 5, 5, 5, 5, 4095, 4095));
    send_query(make_query(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0));
    send_query(make_query(32767, 32767, -32768, 32767, 32767, -32768, 2047, 2047));
    send_query(make_query(-32768, 32767, 32767, 32767, 0, -32768, 4095, 0));
    send_query(make_query(0, 0, 16000, 0, 0, 16000, 639, 479));
    send_query(make_query(0, 0, 16000, 0, 0, 16000, 640, 0));
    send_query(make_query(0, 0, 16000, 0, 0, 16000, 0, 480));
    q = make_query(0, 0, 1600, 0, 0, 1600, 3, 4);
    q.depth_a = 16'hFFFF;
    q.depth_b = 16'hFFFF;
    q.depth_c = 16'hFFFF;
    send_query(q);
    q.depth_a = 16'h0000;
    q.depth_b = 16'h0000;
    q.depth_c = 16'h0000;
    send_query(q);
  endtask

  initial begin
    int widths[7] = '{640, 1, 4096, 8191, 0, 2047, 1000};
    int heights[7] = '{480, 1, 4096, 8191, 100, 4095, 37};
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    directed_queries();
    drain();
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_SCREEN_WIDTH, widths[ph]);
      write_reg(REG_SCREEN_HEIGHT, heights[ph]);
      cur_w = widths[ph];
      no_idle = (ph == 2);
      if (ph == 6) directed_queries();
      for (int k = 0; k < 140; k++) begin
        if (ph == 3 && k == 10) hold_request = 1'b1;
        if (ph == 4 && k == 70) drain();
        send_query(random_query());
      end
      drain();
    end
    no_idle = 1'b0;
    drain();
    $display("Sent %0d coverage queries over seven screen sizes; %0d covered, %0d degenerate.",
             items_sent, covered_seen, degen_seen);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
